[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/salfh_pkg.sv]
// ----------------------------------------------------------------------------
// Slot allocator package
// Codes, reset values and the word search shared by the allocator modules.
// ----------------------------------------------------------------------------
package salfh_pkg;

  localparam int SLOTS_DEFAULT = 4096;
  localparam int WORD_BITS = 64;
  localparam int POS_W = 6;

  localparam int CFG_DW = 13;
  localparam int CFG_IW = 2;
  localparam int CNT_W = 13;
  localparam int IDX_W = 12;

  localparam logic [CFG_DW-1:0] ACTIVE_LIMIT_RESET = 13'd4096;
  localparam logic [CFG_DW-1:0] BUDGET_RESET = 13'd2048;
  localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

  localparam logic [CFG_IW-1:0] CFG_ACTIVE_LIMIT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_BUDGET = 2'd1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_NEW_FRAME = 2'd2;
  localparam logic [1:0] OP_RESET_ALL = 2'd3;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_TAKEOVER = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic             at_end;
  } scan_res_t;

  function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) begin
        p = POS_W'(j);
      end
    end
    return p;
  endfunction

endpackage

[rtl/salfh_scan.sv]
// ----------------------------------------------------------------------------
// Map word search
// Masks one map word to the window between the hint and the bound and finds
// its lowest inactive slot.
// ----------------------------------------------------------------------------
module salfh_scan #(
  parameter int XW = 19
) (
  input  logic [salfh_pkg::WORD_BITS-1:0] word,
  input  logic [XW-1:0]                   base,
  input  logic [XW-1:0]                   hint,
  input  logic [XW-1:0]                   bound,
  output salfh_pkg::scan_res_t            res
);

  logic [XW-1:0]                   diff_lo;
  logic [XW-1:0]                   diff_hi;
  logic [salfh_pkg::POS_W-1:0]     lo_sh;
  logic [salfh_pkg::WORD_BITS-1:0] lo_mask;
  logic [salfh_pkg::WORD_BITS-1:0] hi_mask;
  logic [salfh_pkg::WORD_BITS-1:0] cand;

  always_comb begin
    diff_lo = hint - base;
    diff_hi = bound - base;
    lo_sh = (hint > base) ? diff_lo[salfh_pkg::POS_W-1:0] : '0;
    lo_mask = {salfh_pkg::WORD_BITS{1'b1}} << lo_sh;
    if (diff_hi >= XW'(salfh_pkg::WORD_BITS)) begin
      hi_mask = {salfh_pkg::WORD_BITS{1'b1}};
    end else begin
      hi_mask = (salfh_pkg::WORD_BITS'(1) << diff_hi[salfh_pkg::POS_W-1:0])
                - salfh_pkg::WORD_BITS'(1);
    end
    cand = ~word & lo_mask & hi_mask;
    res.found = |cand;
    res.pos = salfh_pkg::lowest_set(cand);
    res.at_end = (base + XW'(salfh_pkg::WORD_BITS)) >= bound;
  end

endmodule

[rtl/slot_allocator_lowest_free_hint.sv]
// ----------------------------------------------------------------------------
// Lowest-free slot allocator
// Grants slots from a map of active flags, searching upward from a hint one
// 64-bit map word per cycle, under a per-frame allocation budget.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  request   in_valid / in_ready     operation, slot_index
//  result    out_valid / out_ready   status, granted_slot
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Refused allocate, new frame and out-of-range free go straight to the result;
// free reads the map word and then clears the slot in it, and allocate searches
// one map word at a time from the hint, with a takeover step when slot 0 is taken
// over. Reset all and reset run a clearing pass over all ceil(SLOTS/64) map words
// (64 by default), during which no request is accepted.
// A stalled result holds the block before it returns to accept requests.
//
module slot_allocator_lowest_free_hint #(
  parameter int SLOTS = salfh_pkg::SLOTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [salfh_pkg::IDX_W-1:0]      slot_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [salfh_pkg::IDX_W-1:0]      granted_slot,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salfh_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [salfh_pkg::CFG_DW-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int SW = $clog2(SLOTS + 1);
  localparam int XW = SW + 6;
  localparam int WB = salfh_pkg::WORD_BITS;
  localparam int WORDS = (SLOTS + WB - 1) / WB;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW = salfh_pkg::POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAKE = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                      state, state_next;
  logic [SW-1:0]                   hint, hint_next;
  logic [salfh_pkg::CNT_W-1:0]     count, count_next;
  logic [salfh_pkg::CFG_DW-1:0]    active_limit;
  logic [salfh_pkg::CFG_DW-1:0]    budget;
  logic [XW-1:0]                   base, base_next;
  logic [AW-1:0]                   waddr, waddr_next;
  logic [PW-1:0]                   req_pos, req_pos_next;
  logic [AW-1:0]                   clr_cnt, clr_cnt_next;
  logic                            clr_reply, clr_reply_next;
  logic [1:0]                      res_status, res_status_next;
  logic [salfh_pkg::IDX_W-1:0]     res_slot, res_slot_next;
  logic                            out_valid_next;
  logic                            out_load;

  logic [WB-1:0]                   mem [WORDS];
  logic [WB-1:0]                   rd_data;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [WB-1:0]                   wr_data;

  logic [XW-1:0]                   hint_x;
  logic [XW-1:0]                   bound_x;
  logic [XW-1:0]                   idx_x;
  logic [XW-1:0]                   base_inc;
  logic [XW-1:0]                   slot_x;
  salfh_pkg::scan_res_t            scan;

  assign hint_x = XW'(hint);
  assign idx_x = XW'(slot_index);
  assign bound_x = (32'(active_limit) < 32'(SLOTS)) ? XW'(active_limit) : XW'(SLOTS);
  assign base_inc = base + XW'(WB);
  assign slot_x = base + XW'(scan.pos);

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  salfh_scan #(
    .XW(XW)
  ) u_scan (
    .word  (rd_data),
    .base  (base),
    .hint  (hint_x),
    .bound (bound_x),
    .res   (scan)
  );

  always_comb begin
    state_next = state;
    hint_next = hint;
    count_next = count;
    base_next = base;
    waddr_next = waddr;
    req_pos_next = req_pos;
    clr_cnt_next = clr_cnt;
    clr_reply_next = clr_reply;
    res_status_next = res_status;
    res_slot_next = res_slot;
    out_load = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt;
        if (clr_cnt == AW'(WORDS - 1)) begin
          clr_cnt_next = '0;
          clr_reply_next = 1'b0;
          res_status_next = salfh_pkg::ST_NONE;
          res_slot_next = '0;
          state_next = clr_reply ? S_FINISH : S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = salfh_pkg::ST_NONE;
          res_slot_next = '0;
          unique case (operation)
            salfh_pkg::OP_ALLOC: begin
              if (count > budget) begin
                res_status_next = salfh_pkg::ST_REFUSED;
                state_next = S_FINISH;
              end else begin
                if (count != salfh_pkg::CNT_MAX) begin
                  count_next = count + salfh_pkg::CNT_W'(1);
                end
                if (hint_x >= bound_x) begin
                  state_next = S_TAKE;
                end else begin
                  base_next = hint_x & ~XW'(WB - 1);
                  rd_addr = hint_x[AW+PW-1:PW];
                  state_next = S_SCAN;
                end
              end
            end
            salfh_pkg::OP_FREE: begin
              if (32'(slot_index) < 32'(SLOTS)) begin
                rd_addr = idx_x[AW+PW-1:PW];
                waddr_next = idx_x[AW+PW-1:PW];
                req_pos_next = slot_index[PW-1:0];
                if (hint_x > idx_x) begin
                  hint_next = SW'(slot_index);
                end
                state_next = S_FREE;
              end else begin
                state_next = S_FINISH;
              end
            end
            salfh_pkg::OP_NEW_FRAME: begin
              count_next = '0;
              state_next = S_FINISH;
            end
            salfh_pkg::OP_RESET_ALL: begin
              hint_next = '0;
              clr_cnt_next = '0;
              clr_reply_next = 1'b1;
              state_next = S_CLEAR;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan.found) begin
          wr_en = 1'b1;
          wr_addr = base[AW+PW-1:PW];
          wr_data = rd_data | (WB'(1) << scan.pos);
          hint_next = SW'(slot_x + XW'(1));
          res_status_next = salfh_pkg::ST_GRANT;
          res_slot_next = salfh_pkg::IDX_W'(slot_x);
          state_next = S_FINISH;
        end else if (scan.at_end) begin
          state_next = S_TAKE;
        end else begin
          base_next = base_inc;
          rd_addr = base_inc[AW+PW-1:PW];
        end
      end
      S_TAKE: begin
        wr_en = 1'b1;
        wr_data = rd_data | WB'(1);
        res_status_next = salfh_pkg::ST_TAKEOVER;
        res_slot_next = '0;
        state_next = S_FINISH;
      end
      S_FREE: begin
        wr_en = 1'b1;
        wr_addr = waddr;
        wr_data = rd_data & ~(WB'(1) << req_pos);
        res_status_next = salfh_pkg::ST_NONE;
        res_slot_next = '0;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      hint <= '0;
      count <= '0;
      clr_cnt <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
      active_limit <= salfh_pkg::ACTIVE_LIMIT_RESET;
      budget <= salfh_pkg::BUDGET_RESET;
    end else begin
      state <= state_next;
      hint <= hint_next;
      count <= count_next;
      clr_cnt <= clr_cnt_next;
      clr_reply <= clr_reply_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        if (cfg_index == salfh_pkg::CFG_ACTIVE_LIMIT) begin
          active_limit <= cfg_data;
        end else if (cfg_index == salfh_pkg::CFG_FRAME_BUDGET) begin
          budget <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    waddr <= waddr_next;
    req_pos <= req_pos_next;
    res_status <= res_status_next;
    res_slot <= res_slot_next;
    if (out_load) begin
      status <= res_status;
      granted_slot <= res_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  `ASSERT_ALWAYS(a_hint_range, XW'(hint) <= XW'(SLOTS), "free hint beyond slot count")
  `ASSERT_IMPL(a_slot_zero, out_valid && (status != salfh_pkg::ST_GRANT),
               granted_slot == '0, "non-grant result carries a slot")
  `ASSERT_NEXT(a_reset_all, in_valid && in_ready && (operation == salfh_pkg::OP_RESET_ALL),
               (state == S_CLEAR) && (hint == '0), "reset all did not start clearing")
  `ASSERT_IMPL(a_scan_window, state == S_SCAN, base < bound_x, "search word beyond bound")

endmodule

[verif/slot_allocator_lowest_free_hint_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate, free, new frame and reset all requests into the lowest-free
// slot allocator with random gaps and result stalls, predicts every status and
// granted slot from its own copy of the map, hint and frame count, and compares
// each result in order. Both registers are swept through their extremes.
// ----------------------------------------------------------------------------
module slot_allocator_lowest_free_hint_test;

  localparam int SLOT_COUNT = salfh_pkg::SLOTS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [salfh_pkg::CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [salfh_pkg::CFG_IW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [1:0]                  status;
    logic [salfh_pkg::IDX_W-1:0] slot;
  } slot_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   operation = salfh_pkg::OP_ALLOC;
  logic [salfh_pkg::IDX_W-1:0]  slot_index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   status;
  logic [salfh_pkg::IDX_W-1:0]  granted_slot;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [salfh_pkg::CFG_IW-1:0] cfg_index = salfh_pkg::CFG_ACTIVE_LIMIT;
  logic [salfh_pkg::CFG_DW-1:0] cfg_data = '0;

  // Predicted state of the allocator.
  bit                           slot_busy [SLOT_COUNT];
  int                           free_hint = 0;
  logic [salfh_pkg::CNT_W-1:0]  alloc_count = '0;
  logic [salfh_pkg::CFG_DW-1:0] limit_reg = salfh_pkg::ACTIVE_LIMIT_RESET;
  logic [salfh_pkg::CFG_DW-1:0] budget_reg = salfh_pkg::BUDGET_RESET;

  slot_result_t                 pending_results [$];
  logic [salfh_pkg::IDX_W-1:0]  granted_slots [$];
  int                           mismatches = 0;
  int                           quiet_cycles = 0;
  int                           source_idle_pct = 30;
  int                           sink_idle_pct = 30;
  int                           sink_stall = 0;
  int                           hold_off_asked = 0;
  int                           hold_off_served = 0;

  slot_allocator_lowest_free_hint #(
    .SLOTS(SLOT_COUNT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .granted_slot(granted_slot),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap(input int idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 15);
    return $urandom_range(3, 1);
  endfunction

  function automatic slot_result_t predict_slot_request(
    input logic [1:0] op,
    input logic [salfh_pkg::IDX_W-1:0] idx
  );
    slot_result_t r;
    int bound;
    int n;
    r.status = salfh_pkg::ST_NONE;
    r.slot = '0;
    case (op)
      salfh_pkg::OP_ALLOC: begin
        if (alloc_count > budget_reg) begin
          r.status = salfh_pkg::ST_REFUSED;
        end else begin
          if (alloc_count != salfh_pkg::CNT_MAX) alloc_count++;
          bound = (limit_reg < SLOT_COUNT) ? int'(limit_reg) : SLOT_COUNT;
          r.status = salfh_pkg::ST_TAKEOVER;
          for (n = free_hint; n < bound; n++) begin
            if (!slot_busy[n]) begin
              slot_busy[n] = 1'b1;
              free_hint = n + 1;
              r.status = salfh_pkg::ST_GRANT;
              r.slot = salfh_pkg::IDX_W'(n);
              break;
            end
          end
          if (r.status == salfh_pkg::ST_TAKEOVER) slot_busy[0] = 1'b1;
        end
      end
      salfh_pkg::OP_FREE: begin
        if (idx < SLOT_COUNT) begin
          slot_busy[idx] = 1'b0;
          if (free_hint > idx) free_hint = idx;
        end
      end
      salfh_pkg::OP_NEW_FRAME: begin
        alloc_count = '0;
      end
      default: begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        free_hint = 0;
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [1:0] op,
                              input logic [salfh_pkg::IDX_W-1:0] idx);
    int gap;
    slot_result_t r;
    gap = pick_gap(source_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_slot_request(op, idx);
    pending_results.push_back(r);
    if (r.status == salfh_pkg::ST_GRANT) granted_slots.push_back(r.slot);
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [salfh_pkg::CFG_IW-1:0] idx,
                                input logic [salfh_pkg::CFG_DW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      salfh_pkg::CFG_ACTIVE_LIMIT: limit_reg = value;
      salfh_pkg::CFG_FRAME_BUDGET: budget_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_operations;
    source_idle_pct = 30;
    sink_idle_pct = 30;
    send_request(salfh_pkg::OP_ALLOC, '1);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, 12'hAAA);
    send_request(salfh_pkg::OP_FREE, 12'd1);
    send_request(salfh_pkg::OP_ALLOC, 12'h555);
    send_request(salfh_pkg::OP_FREE, 12'd4095);
    send_request(salfh_pkg::OP_ALLOC, '0);
    // Freeing slot 0 a second time frees a slot that is already clear.
    send_request(salfh_pkg::OP_FREE, 12'd0);
    send_request(salfh_pkg::OP_FREE, 12'd0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_NEW_FRAME, '1);
    send_request(salfh_pkg::OP_RESET_ALL, '1);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
  endtask

  task automatic test_active_limit;
    write_register(salfh_pkg::CFG_ACTIVE_LIMIT, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    write_register(salfh_pkg::CFG_ACTIVE_LIMIT, '1);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    write_register(salfh_pkg::CFG_ACTIVE_LIMIT, 13'd2);
    send_request(salfh_pkg::OP_RESET_ALL, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_FREE, 12'd1);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    // Spare register indices must leave both settings untouched.
    write_register(CFG_SPARE_LO, '1);
    write_register(CFG_SPARE_HI, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    write_register(salfh_pkg::CFG_ACTIVE_LIMIT, salfh_pkg::ACTIVE_LIMIT_RESET);
  endtask

  task automatic test_frame_budget;
    write_register(salfh_pkg::CFG_FRAME_BUDGET, '0);
    send_request(salfh_pkg::OP_NEW_FRAME, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    send_request(salfh_pkg::OP_NEW_FRAME, '0);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    write_register(salfh_pkg::CFG_FRAME_BUDGET, '1);
    send_request(salfh_pkg::OP_ALLOC, '0);
    wait_for_results();
    write_register(salfh_pkg::CFG_FRAME_BUDGET, salfh_pkg::BUDGET_RESET);
  endtask

  task automatic test_result_backpressure;
    int k;
    source_idle_pct = 0;
    sink_idle_pct = 0;
    hold_off_asked++;
    for (k = 0; k < 24; k++) begin
      send_request((k % 3 == 2) ? salfh_pkg::OP_FREE : salfh_pkg::OP_ALLOC,
                   salfh_pkg::IDX_W'(k));
    end
    wait_for_results();
  endtask

  task automatic send_random_items(input int count);
    int k;
    int pick;
    int pos;
    logic [salfh_pkg::IDX_W-1:0] idx;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      idx = salfh_pkg::IDX_W'($urandom);
      if (pick < 55) begin
        send_request(salfh_pkg::OP_ALLOC, idx);
      end else if (pick < 85) begin
        if (granted_slots.size() != 0 && $urandom_range(3) != 0) begin
          pos = $urandom_range(granted_slots.size() - 1);
          idx = granted_slots[pos];
          granted_slots.delete(pos);
        end
        send_request(salfh_pkg::OP_FREE, idx);
      end else if (pick < 96) begin
        send_request(salfh_pkg::OP_NEW_FRAME, idx);
      end else begin
        granted_slots.delete();
        send_request(salfh_pkg::OP_RESET_ALL, idx);
      end
    end
  endtask

  task automatic test_random_traffic;
    int limits [6] = '{4096, 64, 300, 0, 8191, 0};
    int budgets [6] = '{2048, 12, 4096, 3, 8191, 0};
    int idle_pcts [6] = '{30, 0, 60, 30, 10, 45};
    int p;
    for (p = 0; p < 6; p++) begin
      if (p == 5) begin
        limits[p] = $urandom_range(4096);
        budgets[p] = $urandom_range(64);
      end
      wait_for_results();
      write_register(salfh_pkg::CFG_ACTIVE_LIMIT, salfh_pkg::CFG_DW'(limits[p]));
      write_register(salfh_pkg::CFG_FRAME_BUDGET, salfh_pkg::CFG_DW'(budgets[p]));
      source_idle_pct = idle_pcts[p];
      sink_idle_pct = idle_pcts[5 - p];
      send_random_items(100);
    end
    wait_for_results();
  endtask

  always @(negedge clk) begin
    if (hold_off_served != hold_off_asked) begin
      hold_off_served = hold_off_asked;
      sink_stall = HOLD_OFF_CYCLES;
    end else if (sink_stall == 0) begin
      sink_stall = pick_gap(sink_idle_pct);
    end
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                 $time, status, granted_slot);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          mismatches++;
        end
        if (granted_slot !== want.slot) begin
          $display("%0t: granted_slot expected %0d, got %0d", $time, want.slot, granted_slot);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_operations();
    test_active_limit();
    test_frame_budget();
    test_result_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/salfh_pkg.sv
rtl/salfh_scan.sv
rtl/slot_allocator_lowest_free_hint.sv
verif/slot_allocator_lowest_free_hint_test.sv
